/* design/psm_pkg.sv */
// Shared types and sizing constants for the pair-sum match finder.
// Used by psm_cell, psm_ring and pair_sum_match_finder; depends on nothing.
package psm_pkg;

  // Number of table cells in the ring.
  localparam int TABLE_ENTRIES = 1024;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int FILL_W        = $clog2(TABLE_ENTRIES + 1);

  // Fixed field widths.
  localparam int KEY_W = 32;
  localparam int POS_W = 10;
  localparam int CNT_W = 11;

  // One input transfer.
  typedef struct packed {
    logic signed [KEY_W-1:0] value;
    logic                    last;
  } item_t;

  // One result transfer.
  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] first_position;
    logic [POS_W-1:0] second_position;
    logic             overflow;
  } result_t;

  // Contents of one table cell.
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [POS_W-1:0] pos;
  } entry_t;

  // Write request from the controller into the ring.
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
    entry_t           entry;
  } ring_wr_t;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE
  } state_t;

endpackage

/* design/psm_cell.sv */
// One storage cell of the table ring: holds a key and its position.
// Depends on psm_pkg for the entry type.
module psm_cell (
  input  logic            clk,
  input  logic            shift,
  input  logic            load,
  input  psm_pkg::entry_t from_next,
  input  psm_pkg::entry_t load_entry,
  output psm_pkg::entry_t entry
);

  // Take the neighbour's entry while the ring rotates, otherwise accept a write.
  always_ff @(posedge clk) begin
    if (shift) begin
      entry <= from_next;
    end else if (load) begin
      entry <= load_entry;
    end
  end

endmodule

/* design/psm_ring.sv */
// Ring of table cells that rotates one place per cycle towards cell 0 while shift is high.
// Depends on psm_pkg and psm_cell.
module psm_ring (
  input  logic              clk,
  input  logic              shift,
  input  psm_pkg::ring_wr_t wr,
  output psm_pkg::entry_t   head
);
  import psm_pkg::*;

  entry_t cells [TABLE_ENTRIES];

  // Each cell takes from its upper neighbour; the top cell wraps round to cell 0.
  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    localparam int NEXT = (i + 1) % TABLE_ENTRIES;
    logic load;

    assign load = wr.en && (wr.idx == IDX_W'(i));

    psm_cell u_cell (
      .clk        (clk),
      .shift      (shift),
      .load       (load),
      .from_next  (cells[NEXT]),
      .load_entry (wr.entry),
      .entry      (cells[i])
    );
  end

  // The controller compares against whatever sits in cell 0.
  assign head = cells[0];

endmodule

/* design/pair_sum_match_finder.sv */
// Pair-sum match finder: top level with controller, result register and table ring.
// Steps: an item is taken in the idle state, the ring makes a full turn past the comparator in
// the scan state, and the update state then registers the result; a stalled result holds it.
// A searched item is not taken before the previous one has left the update state; items after
// a match are taken one per cycle. Reset clears all control state and empties
// the table through its fill count; cell contents are not cleared and no sweep is needed.
module pair_sum_match_finder (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_stall,
  input  psm_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_stall,
  output psm_pkg::result_t result,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [31:0]      cfg_data
);
  import psm_pkg::*;

  state_t state, state_next;

  logic [KEY_W-1:0]  target_sum;
  logic [FILL_W-1:0] fill;
  logic [CNT_W-1:0]  item_count;
  logic              match_done;
  logic              overflow_seen;
  logic [IDX_W-1:0]  step;
  logic              hit;
  logic              same;

  logic [KEY_W-1:0]  val;
  logic [KEY_W-1:0]  want;
  logic              fits;
  logic              last_q;
  logic [POS_W-1:0]  pos;
  logic [POS_W-1:0]  hit_pos;
  logic [IDX_W-1:0]  same_idx;

  logic              item_accept;
  logic              last_step;
  logic              head_valid;
  logic              produce;
  logic              upd_go;
  logic              table_full;
  logic              ovf_set;
  logic              shift;
  ring_wr_t          ring_wr;
  entry_t            head;
  logic [KEY_W:0]    diff;

  // Handshake terms shared by the blocks below.
  assign item_accept = item_valid && !item_stall;
  assign cfg_ready   = 1'b1;
  assign last_step   = (step == IDX_W'(TABLE_ENTRIES - 1));
  assign head_valid  = (FILL_W'(step) < fill);
  assign table_full  = (fill == FILL_W'(TABLE_ENTRIES));
  assign produce     = hit || last_q;
  assign upd_go      = (state == ST_UPDATE) && !(produce && result_valid && result_stall);
  assign ovf_set     = !hit && !same && table_full;

  // Difference formed one bit wider than the operands so that it cannot wrap.
  assign diff = {target_sum[KEY_W-1], target_sum} - {item.value[KEY_W-1], item.value};

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (item_accept && !match_done) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (last_step) begin
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (upd_go) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Controller outputs: input stall, ring rotation and ring write.
  always_comb begin
    item_stall          = 1'b1;
    shift               = 1'b0;
    ring_wr.en          = 1'b0;
    ring_wr.idx         = same ? same_idx : fill[IDX_W-1:0];
    ring_wr.entry.key   = val;
    ring_wr.entry.pos   = pos;
    case (state)
      ST_IDLE: begin
        item_stall = 1'b0;
      end
      ST_SCAN: begin
        shift = 1'b1;
      end
      ST_UPDATE: begin
        ring_wr.en = upd_go && !hit && (same || !table_full);
      end
      default: begin
        item_stall = 1'b1;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      target_sum    <= '0;
      fill          <= '0;
      item_count    <= '0;
      match_done    <= 1'b0;
      overflow_seen <= 1'b0;
      step          <= '0;
      hit           <= 1'b0;
      same          <= 1'b0;
      result_valid  <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg_valid && cfg_ready) begin
        target_sum <= cfg_data;
      end

      // An update that produces a result loads it; otherwise a taken result leaves the register.
      if (upd_go && produce) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          step <= '0;
          hit  <= 1'b0;
          same <= 1'b0;
          if (item_accept && match_done && item.last) begin
            fill          <= '0;
            item_count    <= '0;
            match_done    <= 1'b0;
            overflow_seen <= 1'b0;
          end
        end
        ST_SCAN: begin
          step <= last_step ? '0 : step + 1'b1;
          if (head_valid && fits && !hit && head.key == want) begin
            hit <= 1'b1;
          end
          if (head_valid && !same && head.key == val) begin
            same <= 1'b1;
          end
        end
        ST_UPDATE: begin
          if (upd_go) begin
            if (last_q) begin
              fill          <= '0;
              item_count    <= '0;
              match_done    <= 1'b0;
              overflow_seen <= 1'b0;
            end else begin
              if (hit) begin
                match_done <= 1'b1;
              end
              if (!hit && !same && !table_full) begin
                fill <= fill + 1'b1;
              end
              if (ovf_set) begin
                overflow_seen <= 1'b1;
              end
              if (item_count != '1) begin
                item_count <= item_count + 1'b1;
              end
            end
          end
        end
        default: begin
          step <= '0;
        end
      endcase
    end
  end

  // Item and search payload registers.
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && item_accept) begin
      val    <= item.value;
      want   <= diff[KEY_W-1:0];
      fits   <= (diff[KEY_W] == diff[KEY_W-1]);
      last_q <= item.last;
      pos    <= item_count[POS_W-1:0];
    end
    if (state == ST_SCAN && head_valid) begin
      if (fits && !hit && head.key == want) begin
        hit_pos <= head.pos;
      end
      if (!same && head.key == val) begin
        same_idx <= step;
      end
    end
  end

  // Result register, loaded when the update cycle produces a transfer.
  always_ff @(posedge clk) begin
    if (upd_go && produce) begin
      result.found           <= hit;
      result.first_position  <= hit ? hit_pos : '0;
      result.second_position <= hit ? pos : '0;
      result.overflow        <= hit ? overflow_seen : (overflow_seen || ovf_set);
    end
  end

  // Table of stored keys and positions.
  psm_ring u_ring (
    .clk   (clk),
    .shift (shift),
    .wr    (ring_wr),
    .head  (head)
  );

  // The fill count never passes the table size.
  assert property (@(posedge clk) disable iff (rst)
    fill <= FILL_W'(TABLE_ENTRIES))
    else $error("fill count beyond table size");

  // The update cycle only follows a complete ring turn, so the ring is aligned.
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_UPDATE) |-> (step == '0))
    else $error("update reached with ring out of alignment");

  // Overflow is only recorded when the table is full.
  assert property (@(posedge clk) disable iff (rst)
    $rose(overflow_seen) |-> ($past(table_full)))
    else $error("overflow recorded with free entries");

  // A new result only comes out of an update cycle.
  assert property (@(posedge clk) disable iff (rst)
    (result_valid && !$past(result_valid)) |-> ($past(state) == ST_UPDATE))
    else $error("result produced outside update");

  // A last item after a match empties the table at once.
  assert property (@(posedge clk) disable iff (rst)
    (item_accept && match_done && item.last) |=> (fill == '0 && !match_done))
    else $error("table not cleared after last item");

endmodule

/* dv/pair_sum_match_finder_tb.sv */
// Self-checking testbench for the pair-sum match finder.
// Drives arrays of signed values, predicts each pair or not-found result and checks it.
// Depends on psm_pkg and the pair_sum_match_finder top level.
module pair_sum_match_finder_tb;
  import psm_pkg::*;

  localparam int CLK_PERIOD   = 20;
  localparam int RESET_CYCLES = 11;
  localparam int LONG_ITEMS   = 1300;
  localparam int SHORT_ITEMS  = 350;
  localparam int BLOCK_ITEMS  = 100;
  localparam int CALM_ITEMS   = 100;
  localparam int HOLD_CYCLES  = 20000;
  localparam int QUEUE_AHEAD  = 48;
  localparam int POS_LIMIT    = 2047;

  localparam logic [KEY_W-1:0] INT_MAX = 32'h7FFF_FFFF;
  localparam logic [KEY_W-1:0] INT_MIN = 32'h8000_0000;

  logic             clk          = 1'b0;
  logic             rst          = 1'b1;
  logic             item_valid   = 1'b0;
  logic             item_stall;
  item_t            item         = '0;
  logic             result_valid;
  logic             result_stall = 1'b0;
  result_t          result;
  logic             cfg_valid    = 1'b0;
  logic             cfg_ready;
  logic [31:0]      cfg_data     = '0;

  // Stimulus and expectation stores.
  item_t   pending_items[$];
  result_t expected_results[$];

  // Predictor state: one array in progress.
  logic [POS_W-1:0] key_pos[bit [KEY_W-1:0]];
  logic [CNT_W-1:0] arr_count       = '0;
  bit               pair_done       = 1'b0;
  bit               table_full_seen = 1'b0;
  logic [KEY_W-1:0] target_now      = '0;

  // Run control shared between the stimulus, driver and monitor.
  bit          calm         = 1'b0;
  bit          hold_request = 1'b0;
  int unsigned idle_pct     = 0;
  int unsigned stall_pct    = 0;

  // Bookkeeping.
  int unsigned mismatches    = 0;
  int unsigned searched_items = 0;
  int unsigned arrays_done   = 0;
  int unsigned pairs_found   = 0;
  int unsigned pairs_missing = 0;
  int unsigned overflow_seen_count = 0;
  int unsigned target_writes = 0;

  pair_sum_match_finder i_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  // Clock generation.
  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Works out the result, if any, of one accepted item and advances the array state.
  function automatic void predict_pair(item_t it);
    logic [KEY_W:0]   gap;
    logic [KEY_W-1:0] want;
    logic [POS_W-1:0] pos;
    result_t          r;
    if (!pair_done) begin
      searched_items++;
      // The difference is formed one bit wider so that it cannot wrap.
      gap  = {target_now[KEY_W-1], target_now} - {it.value[KEY_W-1], it.value};
      want = gap[KEY_W-1:0];
      pos  = arr_count[POS_W-1:0];
      if ((gap[KEY_W] == gap[KEY_W-1]) && key_pos.exists(want)) begin
        r.found           = 1'b1;
        r.first_position  = key_pos[want];
        r.second_position = pos;
        r.overflow        = table_full_seen;
        expected_results.push_back(r);
        pair_done = 1'b1;
      end else begin
        // A repeated value only moves its position; a new one needs a free entry.
        if (key_pos.exists(it.value) || key_pos.num() < TABLE_ENTRIES) begin
          key_pos[it.value] = pos;
        end else begin
          table_full_seen = 1'b1;
        end
        if (it.last) begin
          r.found           = 1'b0;
          r.first_position  = '0;
          r.second_position = '0;
          r.overflow        = table_full_seen;
          expected_results.push_back(r);
        end
      end
      if (arr_count < POS_LIMIT) arr_count++;
    end
    if (it.last) begin
      key_pos.delete();
      arr_count       = '0;
      pair_done       = 1'b0;
      table_full_seen = 1'b0;
      arrays_done++;
    end
  endfunction

  function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  // Compares one result transfer with the oldest expectation.
  function automatic void check_result(result_t got);
    result_t want;
    if (expected_results.size() == 0) begin
      mismatches++;
      $display("%0t: result with none expected, expected nothing, got %h", $time, got);
      return;
    end
    want = expected_results.pop_front();
    compare_field("found", 32'(want.found), 32'(got.found));
    compare_field("first_position", 32'(want.first_position), 32'(got.first_position));
    compare_field("second_position", 32'(want.second_position), 32'(got.second_position));
    compare_field("overflow", 32'(want.overflow), 32'(got.overflow));
    if (want.found) pairs_found++;
    else pairs_missing++;
    if (want.overflow) overflow_seen_count++;
  endfunction

  // Driver: offers pending items, with random idle bursts between transfers.
  int unsigned send_gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      send_gap   <= 0;
    end else begin
      if (item_valid && !item_stall) predict_pair(item);
      if (item_valid && item_stall) begin
        // A stalled transfer keeps its payload.
      end else if (send_gap != 0) begin
        item_valid <= 1'b0;
        send_gap   <= send_gap - 1;
      end else if (!calm && idle_pct != 0 && $urandom_range(99, 0) < idle_pct) begin
        item_valid <= 1'b0;
        send_gap   <= $urandom_range(6, 0);
      end else if (pending_items.size() != 0) begin
        item       <= pending_items.pop_front();
        item_valid <= 1'b1;
      end else begin
        item_valid <= 1'b0;
      end
    end
  end

  // Monitor: checks result transfers and stalls the block in random bursts,
  // once for a long stretch so that the block backs up into its input.
  int unsigned stall_gap = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
      stall_gap    <= 0;
      hold_left    <= 0;
      hold_done    <= 1'b0;
    end else begin
      if (result_valid && !result_stall) check_result(result);
      if (hold_request && !hold_done) begin
        hold_left    <= HOLD_CYCLES;
        hold_done    <= 1'b1;
        result_stall <= 1'b1;
      end else if (hold_left != 0) begin
        hold_left    <= hold_left - 1;
        result_stall <= 1'b1;
      end else if (stall_gap != 0) begin
        stall_gap    <= stall_gap - 1;
        result_stall <= 1'b1;
      end else if (!calm && stall_pct != 0 && $urandom_range(99, 0) < stall_pct) begin
        stall_gap    <= $urandom_range(6, 0);
        result_stall <= 1'b1;
      end else begin
        result_stall <= 1'b0;
      end
    end
  end

  task automatic send(logic [KEY_W-1:0] v, bit is_last);
    item_t it;
    it.value = v;
    it.last  = is_last;
    pending_items.push_back(it);
  endtask

  // Waits until every item is taken and every result is back, then lets a
  // full table scan go by in case the last item caused no result.
  task automatic settle_block();
    while (pending_items.size() != 0 || item_valid || expected_results.size() != 0) begin
      @(negedge clk);
    end
    repeat (TABLE_ENTRIES + 8) @(posedge clk);
  endtask

  task automatic write_target(logic [KEY_W-1:0] t);
    settle_block();
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= t;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid  <= 1'b0;
    target_now  = t;
    target_writes++;
  endtask

  function automatic logic [KEY_W-1:0] pick_target();
    case ($urandom_range(7, 0))
      0:       return '0;
      1:       return INT_MAX;
      2:       return INT_MIN;
      3, 4:    return 32'($urandom_range(40, 0)) - 32'd20;
      default: return $urandom;
    endcase
  endfunction

  // One short array: small values, partners of earlier values, repeats,
  // extremes and fully random words, with random idling on both sides.
  task automatic random_array();
    logic [KEY_W-1:0] seen[$];
    logic [KEY_W-1:0] v;
    int               len;
    int               r;
    r = $urandom_range(99, 0);
    if (r < 70) len = $urandom_range(6, 1);
    else if (r < 95) len = $urandom_range(20, 7);
    else len = $urandom_range(60, 21);
    case ($urandom_range(3, 0))
      0:       idle_pct <= 0;
      1:       idle_pct <= 5;
      2:       idle_pct <= 20;
      default: idle_pct <= 50;
    endcase
    case ($urandom_range(3, 0))
      0:       stall_pct <= 0;
      1:       stall_pct <= 5;
      2:       stall_pct <= 20;
      default: stall_pct <= 50;
    endcase
    for (int i = 0; i < len; i++) begin
      r = $urandom_range(99, 0);
      if (r < 30) begin
        v = 32'($urandom_range(32, 0)) - 32'd16;
      end else if (r < 55 && seen.size() != 0) begin
        v = target_now - seen[$urandom_range(seen.size() - 1, 0)];
      end else if (r < 70 && seen.size() != 0) begin
        v = seen[$urandom_range(seen.size() - 1, 0)];
      end else if (r < 80) begin
        case ($urandom_range(4, 0))
          0:       v = INT_MIN;
          1:       v = INT_MAX;
          2:       v = '0;
          3:       v = '1;
          default: v = 32'd1;
        endcase
      end else begin
        v = $urandom;
      end
      seen.push_back(v);
      send(v, i == len - 1);
    end
    while (pending_items.size() > QUEUE_AHEAD) @(negedge clk);
  endtask

  // Limit on the whole run.
  initial begin
    #(64'd500_000_000);
    $display("*** FAILED ***");
    $finish;
  end

  // Stimulus sequence and end of run.
  initial begin
    logic [KEY_W-1:0] head;
    logic [KEY_W-1:0] v;
    logic [KEY_W-1:0] long_vals[$];
    int unsigned      goal;
    int unsigned      block_end;

    rst = 1'b1;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Zero target: simple pair, lone item, two zeros, repeated value,
    // and items after a match that the block must ignore.
    write_target('0);
    send(32'd5, 1'b0);
    send(-32'sd5, 1'b1);
    send('0, 1'b1);
    send('0, 1'b0);
    send('0, 1'b1);
    send(32'd7, 1'b0);
    send(32'd7, 1'b0);
    send(32'd3, 1'b1);
    send(32'd1, 1'b0);
    send(-32'sd1, 1'b0);
    send(32'd100, 1'b0);
    send(32'd200, 1'b1);

    // Largest target: differences beyond 32 bits must miss, then a real pair.
    write_target(INT_MAX);
    send(INT_MIN, 1'b0);
    send('1, 1'b0);
    send('0, 1'b0);
    send(INT_MAX, 1'b1);

    // Smallest target: a difference that would wrap onto a stored key must miss.
    write_target(INT_MIN);
    send(INT_MAX, 1'b0);
    send(32'd1, 1'b1);
    send('0, 1'b0);
    send(INT_MIN, 1'b1);

    // Alternating bit patterns that sum to minus one.
    write_target('1);
    send(32'h5555_5555, 1'b0);
    send(32'hAAAA_AAAA, 1'b1);

    // One long array: fills the table, wraps the position, repeats values
    // throughout, and ends on a pair with the first element.
    write_target('0);
    idle_pct  <= 5;
    stall_pct <= 5;
    head = 32'($urandom_range(1_000_000, 1));
    long_vals.push_back(head);
    send(head, 1'b0);
    for (int i = 1; i < LONG_ITEMS - 1; i++) begin
      if (i % 8 == 0) v = long_vals[$urandom_range(long_vals.size() - 1, 0)];
      else v = 32'($urandom_range(1_000_000, 1));
      long_vals.push_back(v);
      send(v, 1'b0);
    end
    send('0 - head, 1'b1);

    // Short random arrays under a series of targets, with one long receiver hold-off.
    goal = searched_items + SHORT_ITEMS;
    while (searched_items < goal) begin
      write_target(pick_target());
      if (target_writes > 5) hold_request <= 1'b1;
      block_end = searched_items + BLOCK_ITEMS;
      while (searched_items < block_end) random_array();
    end

    // Final stretch with no idling on either side.
    write_target(32'($urandom_range(40, 0)) - 32'd20);
    calm <= 1'b1;
    goal = searched_items + CALM_ITEMS;
    while (searched_items < goal) random_array();

    settle_block();
    $display("Covered %0d arrays, %0d searched items, %0d target settings.",
             arrays_done, searched_items, target_writes);
    $display("Results: %0d pairs found, %0d not found, %0d with overflow set.",
             pairs_found, pairs_missing, overflow_seen_count);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
